### hw/rtl/p417_pkg.sv
// p417_pkg: shared types, constants and codes for the PDF417 text compaction
// and GF(929) Reed-Solomon encoder. No dependencies.
`default_nettype none
package p417_pkg;

    localparam int GF_MOD          = 929;
    localparam int PAD_WORD        = 900;
    localparam int SHIFT_LOWER     = 27;
    localparam int SHIFT_NUM       = 28;
    localparam int TAIL_PAD        = 29;
    localparam int PAIR_BASE       = 30;
    localparam int ROOT_BASE       = 3;
    localparam int MAX_LEN_WORD    = 928;

    // floor(2^20 / 929): quotient estimate for products below 2^20
    localparam int RECIP           = 1128;
    localparam int RECIP_SHIFT     = 20;

    localparam int MAX_DATA_WORDS_DEF  = 1024;
    localparam int MAX_CHECK_WORDS_DEF = 512;

    localparam logic [4:0] COLUMNS_RESET = 5'd3;
    localparam logic signed [4:0] ECC_RESET = -5'sd1;

    localparam logic KIND_FEED = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ECC     = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic       last_char;
    } in_t;

    typedef struct packed {
        logic [9:0] codeword;
        logic       is_last;
        logic       error;
    } out_t;

    typedef enum logic [1:0] {
        MODE_UPPER,
        MODE_LOWER,
        MODE_NUM
    } mode_t;

    typedef enum logic [1:0] {
        PH_LOADING,
        PH_EMITTING,
        PH_FINISHED
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PUSH,
        ST_TAIL,
        ST_DINIT,
        ST_DIV,
        ST_PADS,
        ST_LRED,
        ST_GPOW,
        ST_GPOW_W,
        ST_GRD,
        ST_GISS,
        ST_GWAIT,
        ST_RCLR,
        ST_AFETCH,
        ST_ANUM,
        ST_ARD,
        ST_AISS,
        ST_AWAIT,
        ST_FIN,
        ST_POUT
    } state_t;

    // one request to the shared modular multiply unit:
    // result = (x + a*b) mod 929, or (x - a*b) mod 929 when sub is set
    typedef struct packed {
        logic [9:0] a;
        logic [9:0] b;
        logic [9:0] x;
        logic       sub;
    } mm_req_t;

endpackage
`default_nettype wire

### hw/rtl/p417_mulmod.sv
// p417_mulmod: pipelined multiply-accumulate mod 929 through product, quotient, remainder and sum registers.
// Depends on p417_pkg.
`default_nettype none
module p417_mulmod
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire p417_pkg::mm_req_t req,
    output logic                  res_valid,
    output logic [9:0]            res
);

    logic [3:0]  v_reg;
    logic [19:0] p1_reg;
    logic [19:0] p2_reg;
    logic [10:0] q2_reg;
    logic [10:0] r3_reg;
    logic [10:0] s4_reg;
    logic [9:0]  x1_reg, x2_reg, x3_reg;
    logic        sub1_reg, sub2_reg, sub3_reg;

    logic [30:0] qprod;
    logic [20:0] qmul;
    logic [10:0] r_fix;
    logic [10:0] sum;

    always_comb
    begin
        qprod = 31'(p1_reg) * 31'(p417_pkg::RECIP);
        qmul  = 21'(q2_reg) * 21'(p417_pkg::GF_MOD);
        r_fix = (r3_reg >= 11'(p417_pkg::GF_MOD)) ? r3_reg - 11'(p417_pkg::GF_MOD) : r3_reg;
        if (sub3_reg)
            sum = 11'(x3_reg) + 11'(p417_pkg::GF_MOD) - r_fix;
        else
            sum = 11'(x3_reg) + r_fix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            p1_reg   <= '0;
            p2_reg   <= '0;
            q2_reg   <= '0;
            r3_reg   <= '0;
            s4_reg   <= '0;
            x1_reg   <= '0;
            x2_reg   <= '0;
            x3_reg   <= '0;
            sub1_reg <= 1'b0;
            sub2_reg <= 1'b0;
            sub3_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[2:0], req_valid};
            p1_reg   <= 20'(req.a) * 20'(req.b);
            x1_reg   <= req.x;
            sub1_reg <= req.sub;
            q2_reg   <= 11'(qprod >> p417_pkg::RECIP_SHIFT);
            p2_reg   <= p1_reg;
            x2_reg   <= x1_reg;
            sub2_reg <= sub1_reg;
            r3_reg   <= 11'(21'(p2_reg) - qmul);
            x3_reg   <= x2_reg;
            sub3_reg <= sub2_reg;
            s4_reg   <= sum;
        end
    end

    assign res_valid = v_reg[3];
    assign res = (s4_reg >= 11'(p417_pkg::GF_MOD)) ? 10'(s4_reg - 11'(p417_pkg::GF_MOD))
                                                 : 10'(s4_reg);

endmodule
`default_nettype wire

### hw/rtl/pdf417_text_rs_encoder.sv
// pdf417_text_rs_encoder: text compaction into word pairs, length word and padding, then
// GF(929) Reed-Solomon check words; depends on p417_pkg and p417_mulmod.
// Feed items push their text values one by one; a pull item moves to the output state and
// shows its result there, on done, for one cycle (no receiver stall).
// The last character adds a finish sequence on the shared mulmod unit, which builds the
// generator and then folds each symbol word into the remainder. rst_n clears control state.
`default_nettype none
module pdf417_text_rs_encoder
#(
    parameter int MAX_DATA_WORDS  = p417_pkg::MAX_DATA_WORDS_DEF,
    parameter int MAX_CHECK_WORDS = p417_pkg::MAX_CHECK_WORDS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire p417_pkg::in_t cmd,
    output logic               done,
    output p417_pkg::out_t     result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_index,
    input  wire logic [4:0]    cfg_data
);

    // widths derived from the store sizes
    localparam int DIW = $clog2(MAX_DATA_WORDS);
    localparam int WCW = $clog2(MAX_DATA_WORDS + 1);
    localparam int CIW = $clog2(MAX_CHECK_WORDS);
    localparam int KW  = $clog2(MAX_CHECK_WORDS + 1);
    localparam int TW  = $clog2(MAX_DATA_WORDS + MAX_CHECK_WORDS + 32);
    localparam int BW  = $clog2(TW);

    p417_pkg::state_t state_reg, state_next;

    // configuration
    logic [4:0]        columns_reg;
    logic signed [4:0] ecc_reg;

    // text compaction state
    p417_pkg::mode_t   mode_reg;
    p417_pkg::phase_t  phase_reg;
    logic              half_pend_reg;
    logic [4:0]        half_val_reg;
    logic [WCW-1:0]    wc_reg;
    logic              ovf_reg;
    logic [4:0]        vals_reg [3];
    logic [1:0]        nvals_reg;
    logic [1:0]        vidx_reg;
    logic              last_reg;

    // symbol layout
    logic [KW-1:0]     k_reg;
    logic [TW-1:0]     total_reg;
    logic [4:0]        racc_reg;
    logic [BW-1:0]     bit_reg;
    logic [TW-1:0]     sym_len_reg;
    logic [TW-1:0]     lenmod_reg;
    logic [TW-1:0]     emit_reg;
    logic              pull_bad_reg;

    // generator and remainder sequencing
    logic [KW-1:0]     gi_reg;
    logic [KW-1:0]     gj_reg;
    logic [9:0]        pw_reg;
    logic [9:0]        cur_reg;
    logic [TW-1:0]     t_reg;
    logic [KW-1:0]     aj_reg;
    logic [9:0]        num_reg;

    // memories
    logic [9:0] word_mem [MAX_DATA_WORDS];
    logic [9:0] gen_mem  [MAX_CHECK_WORDS];
    logic [9:0] rem_mem  [MAX_CHECK_WORDS];
    logic [9:0] wrd_q, gen_q, rem_q;

    logic           word_we;
    logic [DIW-1:0] word_waddr, word_raddr;
    logic [9:0]     word_wdata;
    logic           gen_we;
    logic [CIW-1:0] gen_waddr, gen_raddr;
    logic           rem_we;
    logic [CIW-1:0] rem_waddr, rem_raddr;
    logic [9:0]     rem_wdata;

    // shared mulmod unit
    logic              mm_valid;
    p417_pkg::mm_req_t mm_req;
    logic              mm_res_valid;
    logic [9:0]        mm_res;

    // combinational helpers
    logic              accept;
    logic              feed_acc;
    p417_pkg::mode_t   mode_eff;
    p417_pkg::mode_t   mode_new;
    logic [4:0]        cv [3];
    logic [1:0]        cn;
    logic [4:0]        push_v;
    logic              store_ok;
    logic [KW-1:0]     k_calc;
    logic [16:0]       k_pow;
    logic [4:0]        cols_eff;
    logic [5:0]        div_nr;
    logic [4:0]        pads;
    logic [TW-1:0]     sym_calc;
    logic [TW-1:0]     out_total;
    logic [9:0]        m_sel;
    logic [10:0]       num_sum;
    logic [9:0]        g_prev;

    p417_mulmod u_mulmod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (mm_valid),
        .req       (mm_req),
        .res_valid (mm_res_valid),
        .res       (mm_res)
    );

    assign accept    = start && !busy;
    assign feed_acc  = accept && (cmd.kind == p417_pkg::KIND_FEED);
    // hold register writes off while an item is at work
    assign cfg_ready = !busy;
    assign store_ok  = (wc_reg != WCW'(MAX_DATA_WORDS));
    assign cols_eff  = (columns_reg == 5'd0) ? 5'd1 : columns_reg;
    assign out_total = sym_len_reg + TW'(k_reg);
    assign push_v    = vals_reg[vidx_reg];

    // classify the character and list the text values it pushes
    always_comb
    begin
        mode_eff = (phase_reg != p417_pkg::PH_LOADING) ? p417_pkg::MODE_UPPER : mode_reg;
        mode_new = mode_eff;
        cv[0] = '0;
        cv[1] = '0;
        cv[2] = '0;
        cn    = 2'd0;
        if (cmd.char_code inside {[8'h41:8'h5A]})
        begin
            mode_new = p417_pkg::MODE_UPPER;
            case (mode_eff)
                p417_pkg::MODE_LOWER:
                begin
                    cv[0] = 5'(p417_pkg::SHIFT_NUM);
                    cv[1] = 5'(p417_pkg::SHIFT_NUM);
                    cv[2] = 5'(cmd.char_code - 8'h41);
                    cn    = 2'd3;
                end
                p417_pkg::MODE_NUM:
                begin
                    cv[0] = 5'(p417_pkg::SHIFT_NUM);
                    cv[1] = 5'(cmd.char_code - 8'h41);
                    cn    = 2'd2;
                end
                default:
                begin
                    cv[0] = 5'(cmd.char_code - 8'h41);
                    cn    = 2'd1;
                end
            endcase
        end
        else if (cmd.char_code inside {[8'h61:8'h7A]})
        begin
            mode_new = p417_pkg::MODE_LOWER;
            if (mode_eff != p417_pkg::MODE_LOWER)
            begin
                cv[0] = 5'(p417_pkg::SHIFT_LOWER);
                cv[1] = 5'(cmd.char_code - 8'h61);
                cn    = 2'd2;
            end
            else
            begin
                cv[0] = 5'(cmd.char_code - 8'h61);
                cn    = 2'd1;
            end
        end
        else if (cmd.char_code inside {[8'h30:8'h39]})
        begin
            mode_new = p417_pkg::MODE_NUM;
            if (mode_eff != p417_pkg::MODE_NUM)
            begin
                cv[0] = 5'(p417_pkg::SHIFT_NUM);
                cv[1] = 5'(cmd.char_code - 8'h30);
                cn    = 2'd2;
            end
            else
            begin
                cv[0] = 5'(cmd.char_code - 8'h30);
                cn    = 2'd1;
            end
        end
    end

    // check word count: 2^(level+1) for a level of 0 or more, none for a negative level, capped at the store size
    always_comb
    begin
        k_pow  = 17'd1 << (ecc_reg + 5'sd1);
        k_calc = '0;
        if (ecc_reg >= 5'sd0)
        begin
            if (32'(k_pow) > 32'(MAX_CHECK_WORDS))
                k_calc = KW'(MAX_CHECK_WORDS);
            else
                k_calc = KW'(k_pow);
        end
    end

    // one restoring division step of total by columns; pads and length
    always_comb
    begin
        div_nr = {racc_reg, total_reg[bit_reg]};
        if (div_nr >= 6'(cols_eff))
            div_nr = div_nr - 6'(cols_eff);
        pads     = (racc_reg == 5'd0) ? 5'd0 : cols_eff - racc_reg;
        sym_calc = TW'(1) + TW'(wc_reg) + TW'(pads);
    end

    // message word fed into the remainder: length, data, then pads
    always_comb
    begin
        if (t_reg == '0)
            m_sel = 10'(lenmod_reg);
        else if (t_reg <= TW'(wc_reg))
            m_sel = wrd_q;
        else
            m_sel = 10'(p417_pkg::PAD_WORD);
        num_sum = 11'(m_sel) + 11'(rem_q);
        g_prev  = (gj_reg >= KW'(2)) ? gen_q : 10'd1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            p417_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.kind == p417_pkg::KIND_PULL)
                        state_next = p417_pkg::ST_POUT;
                    else if (cn != 2'd0)
                        state_next = p417_pkg::ST_PUSH;
                    else if (cmd.last_char)
                        state_next = p417_pkg::ST_TAIL;
                end
            end
            p417_pkg::ST_PUSH:
            begin
                if (vidx_reg + 2'd1 == nvals_reg)
                    state_next = last_reg ? p417_pkg::ST_TAIL : p417_pkg::ST_IDLE;
            end
            p417_pkg::ST_TAIL:  state_next = p417_pkg::ST_DINIT;
            p417_pkg::ST_DINIT: state_next = p417_pkg::ST_DIV;
            p417_pkg::ST_DIV:
            begin
                if (bit_reg == '0)
                    state_next = p417_pkg::ST_PADS;
            end
            p417_pkg::ST_PADS:  state_next = p417_pkg::ST_LRED;
            p417_pkg::ST_LRED:
            begin
                if (32'(lenmod_reg) < 32'(p417_pkg::GF_MOD))
                    state_next = (k_reg == '0) ? p417_pkg::ST_FIN : p417_pkg::ST_GPOW;
            end
            p417_pkg::ST_GPOW:  state_next = p417_pkg::ST_GPOW_W;
            p417_pkg::ST_GPOW_W:
            begin
                if (mm_res_valid)
                    state_next = p417_pkg::ST_GRD;
            end
            p417_pkg::ST_GRD:   state_next = p417_pkg::ST_GISS;
            p417_pkg::ST_GISS:  state_next = p417_pkg::ST_GWAIT;
            p417_pkg::ST_GWAIT:
            begin
                if (mm_res_valid)
                begin
                    if (gj_reg != KW'(1))
                        state_next = p417_pkg::ST_GRD;
                    else if (gi_reg == k_reg)
                        state_next = p417_pkg::ST_RCLR;
                    else
                        state_next = p417_pkg::ST_GPOW;
                end
            end
            p417_pkg::ST_RCLR:
            begin
                if (aj_reg + KW'(1) == k_reg)
                    state_next = p417_pkg::ST_AFETCH;
            end
            p417_pkg::ST_AFETCH: state_next = p417_pkg::ST_ANUM;
            p417_pkg::ST_ANUM:   state_next = p417_pkg::ST_ARD;
            p417_pkg::ST_ARD:    state_next = p417_pkg::ST_AISS;
            p417_pkg::ST_AISS:   state_next = p417_pkg::ST_AWAIT;
            p417_pkg::ST_AWAIT:
            begin
                if (mm_res_valid)
                begin
                    if (aj_reg + KW'(1) != k_reg)
                        state_next = p417_pkg::ST_ARD;
                    else if (t_reg + TW'(1) == sym_len_reg)
                        state_next = p417_pkg::ST_FIN;
                    else
                        state_next = p417_pkg::ST_AFETCH;
                end
            end
            p417_pkg::ST_FIN:  state_next = p417_pkg::ST_IDLE;
            p417_pkg::ST_POUT: state_next = p417_pkg::ST_IDLE;
            default:           state_next = p417_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory / mulmod controls
    always_comb
    begin
        busy       = (state_reg != p417_pkg::ST_IDLE);
        done       = (state_reg == p417_pkg::ST_POUT);
        result     = '0;
        word_we    = 1'b0;
        word_waddr = DIW'(wc_reg);
        word_wdata = 10'(half_val_reg) * 10'(p417_pkg::PAIR_BASE) + 10'(push_v);
        word_raddr = DIW'(emit_reg - TW'(1));
        gen_we     = 1'b0;
        gen_waddr  = CIW'(gj_reg - KW'(1));
        gen_raddr  = CIW'(gj_reg - KW'(2));
        rem_we     = 1'b0;
        rem_waddr  = CIW'(aj_reg);
        rem_wdata  = mm_res;
        rem_raddr  = CIW'(emit_reg - sym_len_reg);
        mm_valid   = 1'b0;
        mm_req     = '0;
        case (state_reg)
            p417_pkg::ST_PUSH:
            begin
                word_we = half_pend_reg && store_ok;
            end
            p417_pkg::ST_TAIL:
            begin
                word_we    = half_pend_reg && store_ok;
                word_wdata = 10'(half_val_reg) * 10'(p417_pkg::PAIR_BASE)
                           + 10'(p417_pkg::TAIL_PAD);
            end
            p417_pkg::ST_GPOW:
            begin
                mm_valid = 1'b1;
                mm_req   = '{a: pw_reg, b: 10'(p417_pkg::ROOT_BASE), x: 10'd0, sub: 1'b0};
            end
            p417_pkg::ST_GISS:
            begin
                mm_valid = 1'b1;
                mm_req   = '{a: pw_reg, b: g_prev, x: cur_reg, sub: 1'b1};
            end
            p417_pkg::ST_GWAIT:
            begin
                gen_we = mm_res_valid;
            end
            p417_pkg::ST_RCLR:
            begin
                rem_we    = 1'b1;
                rem_wdata = 10'd0;
            end
            p417_pkg::ST_AFETCH:
            begin
                word_raddr = DIW'(t_reg - TW'(1));
                rem_raddr  = '0;
            end
            p417_pkg::ST_ARD:
            begin
                gen_raddr = CIW'(aj_reg);
                rem_raddr = CIW'(aj_reg + KW'(1));
            end
            p417_pkg::ST_AISS:
            begin
                mm_valid = 1'b1;
                mm_req   = '{a: num_reg, b: gen_q,
                             x: (aj_reg + KW'(1) < k_reg) ? rem_q : 10'd0, sub: 1'b1};
            end
            p417_pkg::ST_AWAIT:
            begin
                rem_we = mm_res_valid;
            end
            p417_pkg::ST_POUT:
            begin
                if (pull_bad_reg)
                    result = '{codeword: 10'd0, is_last: 1'b0, error: 1'b1};
                else
                begin
                    if (emit_reg == '0)
                        result.codeword = 10'(sym_len_reg);
                    else if (emit_reg <= TW'(wc_reg))
                        result.codeword = wrd_q;
                    else if (emit_reg < sym_len_reg)
                        result.codeword = 10'(p417_pkg::PAD_WORD);
                    else if (rem_q == 10'd0)
                        result.codeword = 10'd0;
                    else
                        result.codeword = 10'(p417_pkg::GF_MOD) - rem_q;
                    result.is_last = (emit_reg + TW'(1) == out_total);
                    result.error   = ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (word_we)
            word_mem[word_waddr] <= word_wdata;
        wrd_q <= word_mem[word_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (gen_we)
            gen_mem[gen_waddr] <= mm_res;
        gen_q <= gen_mem[gen_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rem_we)
            rem_mem[rem_waddr] <= rem_wdata;
        rem_q <= rem_mem[rem_raddr];
    end

    // sequencer registers and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= p417_pkg::ST_IDLE;
            columns_reg   <= p417_pkg::COLUMNS_RESET;
            ecc_reg       <= p417_pkg::ECC_RESET;
            mode_reg      <= p417_pkg::MODE_UPPER;
            phase_reg     <= p417_pkg::PH_LOADING;
            half_pend_reg <= 1'b0;
            half_val_reg  <= '0;
            wc_reg        <= '0;
            ovf_reg       <= 1'b0;
            vals_reg[0]   <= '0;
            vals_reg[1]   <= '0;
            vals_reg[2]   <= '0;
            nvals_reg     <= '0;
            vidx_reg      <= '0;
            last_reg      <= 1'b0;
            k_reg         <= '0;
            total_reg     <= '0;
            racc_reg      <= '0;
            bit_reg       <= '0;
            sym_len_reg   <= '0;
            lenmod_reg    <= '0;
            emit_reg      <= '0;
            pull_bad_reg  <= 1'b0;
            gi_reg        <= '0;
            gj_reg        <= '0;
            pw_reg        <= '0;
            cur_reg       <= '0;
            t_reg         <= '0;
            aj_reg        <= '0;
            num_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    p417_pkg::REG_COLUMNS: columns_reg <= cfg_data;
                    p417_pkg::REG_ECC:     ecc_reg     <= cfg_data;
                    default:               columns_reg <= cfg_data;
                endcase
            end

            case (state_reg)
                p417_pkg::ST_IDLE:
                begin
                    if (feed_acc)
                    begin
                        // a feed after a closed message, read out or not, starts a new one
                        if (phase_reg != p417_pkg::PH_LOADING)
                        begin
                            half_pend_reg <= 1'b0;
                            half_val_reg  <= '0;
                            wc_reg        <= '0;
                            emit_reg      <= '0;
                            ovf_reg       <= 1'b0;
                            phase_reg     <= p417_pkg::PH_LOADING;
                        end
                        mode_reg    <= mode_new;
                        vals_reg[0] <= cv[0];
                        vals_reg[1] <= cv[1];
                        vals_reg[2] <= cv[2];
                        nvals_reg   <= cn;
                        vidx_reg    <= '0;
                        last_reg    <= cmd.last_char;
                    end
                    else if (accept)
                        pull_bad_reg <= (phase_reg != p417_pkg::PH_EMITTING);
                end
                p417_pkg::ST_PUSH:
                begin
                    vidx_reg <= vidx_reg + 2'd1;
                    if (half_pend_reg)
                    begin
                        half_pend_reg <= 1'b0;
                        if (store_ok)
                            wc_reg <= wc_reg + WCW'(1);
                        else
                            ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        half_val_reg  <= push_v;
                        half_pend_reg <= 1'b1;
                    end
                end
                p417_pkg::ST_TAIL:
                begin
                    if (half_pend_reg)
                    begin
                        half_pend_reg <= 1'b0;
                        if (store_ok)
                            wc_reg <= wc_reg + WCW'(1);
                        else
                            ovf_reg <= 1'b1;
                    end
                    k_reg <= k_calc;
                end
                p417_pkg::ST_DINIT:
                begin
                    total_reg <= TW'(1) + TW'(wc_reg) + TW'(k_reg);
                    racc_reg  <= '0;
                    bit_reg   <= BW'(TW - 1);
                end
                p417_pkg::ST_DIV:
                begin
                    racc_reg <= 5'(div_nr);
                    bit_reg  <= bit_reg - BW'(1);
                end
                p417_pkg::ST_PADS:
                begin
                    sym_len_reg <= sym_calc;
                    lenmod_reg  <= sym_calc;
                    if (32'(sym_calc) > 32'(p417_pkg::MAX_LEN_WORD))
                        ovf_reg <= 1'b1;
                    gi_reg <= KW'(1);
                    pw_reg <= 10'd1;
                end
                p417_pkg::ST_LRED:
                begin
                    if (32'(lenmod_reg) >= 32'(p417_pkg::GF_MOD))
                        lenmod_reg <= lenmod_reg - TW'(p417_pkg::GF_MOD);
                end
                p417_pkg::ST_GPOW_W:
                begin
                    if (mm_res_valid)
                    begin
                        pw_reg  <= mm_res;
                        gj_reg  <= gi_reg;
                        cur_reg <= '0;
                    end
                end
                p417_pkg::ST_GISS:
                begin
                    // the old g[j-2] is the current term of the next step down
                    cur_reg <= g_prev;
                end
                p417_pkg::ST_GWAIT:
                begin
                    if (mm_res_valid)
                    begin
                        if (gj_reg != KW'(1))
                            gj_reg <= gj_reg - KW'(1);
                        else
                        begin
                            gi_reg <= gi_reg + KW'(1);
                            aj_reg <= '0;
                        end
                    end
                end
                p417_pkg::ST_RCLR:
                begin
                    if (aj_reg + KW'(1) == k_reg)
                        t_reg <= '0;
                    aj_reg <= aj_reg + KW'(1);
                end
                p417_pkg::ST_ANUM:
                begin
                    num_reg <= (num_sum >= 11'(p417_pkg::GF_MOD))
                             ? 10'(num_sum - 11'(p417_pkg::GF_MOD)) : 10'(num_sum);
                    aj_reg  <= '0;
                end
                p417_pkg::ST_AWAIT:
                begin
                    if (mm_res_valid)
                    begin
                        if (aj_reg + KW'(1) != k_reg)
                            aj_reg <= aj_reg + KW'(1);
                        else
                            t_reg <= t_reg + TW'(1);
                    end
                end
                p417_pkg::ST_FIN:
                begin
                    emit_reg  <= '0;
                    phase_reg <= p417_pkg::PH_EMITTING;
                end
                p417_pkg::ST_POUT:
                begin
                    if (!pull_bad_reg)
                    begin
                        emit_reg <= emit_reg + TW'(1);
                        if (emit_reg + TW'(1) >= out_total)
                            phase_reg <= p417_pkg::PH_FINISHED;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/p417_checker.sv
// p417_checker: port-level assertions for pdf417_text_rs_encoder, bound to it.
// Depends on p417_pkg.
`default_nettype none
module p417_checker
(
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire p417_pkg::in_t  cmd,
    input wire logic           done,
    input wire p417_pkg::out_t result
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown with no item at work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results back to back");

    a_pull_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.kind == p417_pkg::KIND_PULL) |=> done)
        else $error("pull item gave no result");

    a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.error) |-> (result.codeword <= 10'd928))
        else $error("codeword out of range without error");

endmodule

bind pdf417_text_rs_encoder p417_checker u_p417_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
`default_nettype wire

### tb/tb_pdf417_text_rs_encoder.sv
// tb_pdf417_text_rs_encoder: self-checking testbench for the PDF417 text compaction
// and GF(929) Reed-Solomon encoder. Depends on p417_pkg and the encoder RTL.
// Holds its own symbol predictor, a queued driver and a result monitor.
`default_nettype none
module tb_pdf417_text_rs_encoder;

    localparam int DATA_DEPTH  = 1024;
    localparam int CHECK_DEPTH = 512;
    localparam int STALL_LIMIT = 3000000;
    localparam int ITEM_TARGET = 1450;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    p417_pkg::in_t  cmd = '0;
    logic           done;
    p417_pkg::out_t result;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic           cfg_index = p417_pkg::REG_COLUMNS;
    logic [4:0]     cfg_data = '0;

    pdf417_text_rs_encoder u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Symbol predictor: shadow registers and encoder state
    // ---------------------------------------------------------------
    logic [4:0]        sh_columns = p417_pkg::COLUMNS_RESET;
    logic signed [4:0] sh_level = p417_pkg::ECC_RESET;

    p417_pkg::mode_t  enc_mode;
    bit               half_full;
    int unsigned      half_val;
    int unsigned      data_words [DATA_DEPTH];
    int unsigned      data_cnt;
    int unsigned      gen_poly [CHECK_DEPTH];
    int unsigned      rem_poly [CHECK_DEPTH];
    int unsigned      read_ptr;
    p417_pkg::phase_t enc_phase;
    bit               ovf;
    int unsigned      len_word;
    int unsigned      check_cnt;

    p417_pkg::out_t pulled_words_q [$];
    p417_pkg::in_t  item_q [$];

    int fails = 0;
    int gap_left = 0;
    bit no_idle = 1'b0;
    int stall_cycles = 0;
    int queued = 0;

    task automatic clear_symbol();
        enc_mode  = p417_pkg::MODE_UPPER;
        half_full = 1'b0;
        half_val  = 0;
        data_cnt  = 0;
        read_ptr  = 0;
        enc_phase = p417_pkg::PH_LOADING;
        ovf       = 1'b0;
        len_word  = 0;
        check_cnt = 0;
    endtask

    task automatic keep_word(input int unsigned w);
        if (data_cnt >= DATA_DEPTH)
            ovf = 1'b1;
        else
        begin
            data_words[data_cnt] = w;
            data_cnt++;
        end
    endtask

    task automatic push_val(input int unsigned v);
        if (half_full)
        begin
            keep_word(half_val * p417_pkg::PAIR_BASE + v);
            half_full = 1'b0;
        end
        else
        begin
            half_val  = v;
            half_full = 1'b1;
        end
    endtask

    task automatic compact_char(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            // lower to upper needs a double shift, numeric to upper a single one
            if (enc_mode == p417_pkg::MODE_LOWER)
            begin
                push_val(p417_pkg::SHIFT_NUM);
                push_val(p417_pkg::SHIFT_NUM);
            end
            else if (enc_mode == p417_pkg::MODE_NUM)
                push_val(p417_pkg::SHIFT_NUM);
            enc_mode = p417_pkg::MODE_UPPER;
            push_val(c - "A");
        end
        else if (c >= "a" && c <= "z")
        begin
            if (enc_mode != p417_pkg::MODE_LOWER)
                push_val(p417_pkg::SHIFT_LOWER);
            enc_mode = p417_pkg::MODE_LOWER;
            push_val(c - "a");
        end
        else if (c >= "0" && c <= "9")
        begin
            if (enc_mode != p417_pkg::MODE_NUM)
                push_val(p417_pkg::SHIFT_NUM);
            enc_mode = p417_pkg::MODE_NUM;
            push_val(c - "0");
        end
    endtask

    task automatic absorb_word(input int unsigned m);
        int unsigned num;
        int unsigned nxt;
        int unsigned prod;
        num = (m % p417_pkg::GF_MOD + rem_poly[0]) % p417_pkg::GF_MOD;
        for (int j = 0; j < check_cnt; j++)
        begin
            nxt = (j + 1 < check_cnt) ? rem_poly[j + 1] : 0;
            prod = (num * gen_poly[j]) % p417_pkg::GF_MOD;
            rem_poly[j] = (nxt + p417_pkg::GF_MOD - prod) % p417_pkg::GF_MOD;
        end
    endtask

    task automatic close_symbol();
        int unsigned cols;
        int unsigned pads;
        int unsigned pw;
        int unsigned c;
        int unsigned prev;
        int unsigned cur;
        int lvl;
        cols = (sh_columns == 0) ? 1 : sh_columns;
        lvl = sh_level;
        if (half_full)
        begin
            keep_word(half_val * p417_pkg::PAIR_BASE + p417_pkg::TAIL_PAD);
            half_full = 1'b0;
        end
        check_cnt = 0;
        if (lvl >= 0)
        begin
            check_cnt = 2;
            for (int i = 0; i < lvl && check_cnt < CHECK_DEPTH; i++)
                check_cnt *= 2;
            if (check_cnt > CHECK_DEPTH)
                check_cnt = CHECK_DEPTH;
        end
        pads = (cols - (1 + data_cnt + check_cnt) % cols) % cols;
        len_word = 1 + data_cnt + pads;
        if (len_word > p417_pkg::MAX_LEN_WORD)
            ovf = 1'b1;
        // generator product of (x - 3^i), leading 1 implicit
        pw = 1;
        for (int i = 1; i <= check_cnt; i++)
        begin
            pw = (pw * p417_pkg::ROOT_BASE) % p417_pkg::GF_MOD;
            c = (p417_pkg::GF_MOD - pw) % p417_pkg::GF_MOD;
            for (int j = i; j >= 1; j--)
            begin
                prev = (j >= 2) ? gen_poly[j - 2] : 1;
                cur = (j < i) ? gen_poly[j - 1] : 0;
                gen_poly[j - 1] = (cur + c * prev) % p417_pkg::GF_MOD;
            end
        end
        for (int i = 0; i < check_cnt; i++)
            rem_poly[i] = 0;
        absorb_word(len_word);
        for (int i = 0; i < data_cnt; i++)
            absorb_word(data_words[i]);
        for (int i = 0; i < pads; i++)
            absorb_word(p417_pkg::PAD_WORD);
        read_ptr = 0;
        enc_phase = p417_pkg::PH_EMITTING;
    endtask

    task automatic predict_item(input p417_pkg::in_t it);
        p417_pkg::out_t o;
        int unsigned w;
        int unsigned total;
        if (it.kind == p417_pkg::KIND_FEED)
        begin
            if (enc_phase != p417_pkg::PH_LOADING)
                clear_symbol();
            compact_char(it.char_code);
            if (it.last_char)
                close_symbol();
            return;
        end
        if (enc_phase != p417_pkg::PH_EMITTING)
        begin
            o.codeword = '0;
            o.is_last  = 1'b0;
            o.error    = 1'b1;
        end
        else
        begin
            total = len_word + check_cnt;
            if (read_ptr == 0)
                w = len_word;
            else if (read_ptr <= data_cnt)
                w = data_words[(read_ptr - 1) % DATA_DEPTH];
            else if (read_ptr < len_word)
                w = p417_pkg::PAD_WORD;
            else
                w = (p417_pkg::GF_MOD - rem_poly[(read_ptr - len_word) % CHECK_DEPTH])
                    % p417_pkg::GF_MOD;
            o.codeword = w[9:0];
            o.is_last  = (read_ptr + 1 == total);
            o.error    = ovf;
            read_ptr++;
            if (read_ptr >= total)
                enc_phase = p417_pkg::PH_FINISHED;
        end
        pulled_words_q = {pulled_words_q, o};
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // ---------------------------------------------------------------
    // Driver: accept at the rising edge, present the next item at the falling edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            predict_item(cmd);
            void'(item_q.pop_front());
            gap_left = pick_gap();
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left--;
        end
        else if (item_q.size() != 0)
        begin
            start <= 1'b1;
            cmd   <= item_q[0];
        end
        else
            start <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Monitor: each strobed word against the oldest expected word
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        p417_pkg::out_t want;
        if (rst_n && done)
        begin
            if (pulled_words_q.size() == 0)
            begin
                $display("%0t unexpected word: expected none, actual %p", $time, result);
                fails++;
            end
            else
            begin
                want = pulled_words_q.pop_front();
                if (result.codeword !== want.codeword)
                begin
                    $display("%0t codeword: expected %0d, actual %0d",
                             $time, want.codeword, result.codeword);
                    fails++;
                end
                if (result.is_last !== want.is_last)
                begin
                    $display("%0t is_last: expected %0b, actual %0b",
                             $time, want.is_last, result.is_last);
                    fails++;
                end
                if (result.error !== want.error)
                begin
                    $display("%0t error: expected %0b, actual %0b",
                             $time, want.error, result.error);
                    fails++;
                end
            end
        end
    end

    // Watchdog: restart on any accepted item, word or register write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("pdf417_text_rs_encoder regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(input logic idx, input logic [4:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == p417_pkg::REG_COLUMNS)
            sh_columns = val;
        else
            sh_level = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued item is taken, every word has come back and
    // the block has stayed idle with done low.
    task automatic settle();
        int quiet;
        quiet = 0;
        while (quiet < 16)
        begin
            @(negedge clk);
            if (item_q.size() == 0 && pulled_words_q.size() == 0 && !busy && !done)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic add_feed(input logic [7:0] c, input logic last);
        p417_pkg::in_t it;
        it.kind = p417_pkg::KIND_FEED;
        it.char_code = c;
        it.last_char = last;
        item_q = {item_q, it};
        queued++;
    endtask

    task automatic add_pulls(input int n);
        p417_pkg::in_t it;
        for (int i = 0; i < n; i++)
        begin
            it.kind = p417_pkg::KIND_PULL;
            it.char_code = $urandom_range(255);
            it.last_char = $urandom_range(1);
            item_q = {item_q, it};
            queued++;
        end
    endtask

    function automatic int words_left();
        return (enc_phase == p417_pkg::PH_EMITTING)
               ? int'(len_word + check_cnt - read_ptr) : 0;
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'("A" + $urandom_range(25));
        if (r < 60)
            return 8'("a" + $urandom_range(25));
        if (r < 88)
            return 8'("0" + $urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        string dtext;
        int len;
        int r;
        clear_symbol();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // pull while still loading
        add_pulls(1);
        settle();

        // every mode transition, closed by a non-text character
        dtext = "Zz0A9aB!";
        for (int i = 0; i < dtext.len(); i++)
            add_feed(dtext[i], i == dtext.len() - 1);
        settle();
        add_pulls(words_left() + 2);
        settle();

        // 30 columns, check level 0; interrupt the readout with a new symbol
        write_reg(p417_pkg::REG_COLUMNS, 5'd30);
        write_reg(p417_pkg::REG_ECC, 5'd0);
        add_feed("A", 1'b1);
        settle();
        add_pulls(words_left() / 2);
        add_feed("z", 1'b0);
        add_feed("z", 1'b1);
        settle();
        add_pulls(words_left());
        settle();

        // zero columns, level below -1
        write_reg(p417_pkg::REG_COLUMNS, 5'd0);
        write_reg(p417_pkg::REG_ECC, 5'b10000);
        add_feed("a", 1'b1);
        settle();
        add_pulls(words_left() + 1);
        settle();

        // check level 8, the first to fill the check store, on the smallest symbol
        write_reg(p417_pkg::REG_COLUMNS, 5'd1);
        write_reg(p417_pkg::REG_ECC, 5'd8);
        add_feed("7", 1'b1);
        settle();
        add_pulls(words_left());
        settle();

        // overflow: alternate lower and upper to maximize values per character;
        // read only the head of the symbol, the next feed drops the rest
        write_reg(p417_pkg::REG_COLUMNS, 5'd3);
        write_reg(p417_pkg::REG_ECC, 5'd0);
        for (int i = 0; i < 840; i++)
            add_feed((i % 2) ? 8'("A" + $urandom_range(25)) : 8'("a" + $urandom_range(25)),
                     i == 839);
        settle();
        add_pulls(20);
        settle();

        // random symbols under changing settings
        while (queued < ITEM_TARGET)
        begin
            if ($urandom_range(7) == 0)
            begin
                r = $urandom_range(9);
                write_reg(p417_pkg::REG_COLUMNS, (r == 0) ? 5'd0 : (r == 1) ? 5'd31
                                                 : 5'($urandom_range(30, 1)));
                r = $urandom_range(9);
                write_reg(p417_pkg::REG_ECC, (r == 0) ? 5'($urandom_range(31, 16))
                                            : 5'(int'($urandom_range(5)) - 1));
            end
            no_idle = ($urandom_range(3) == 0);
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(12, 1);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(19) == 0)
                    add_pulls(1);
                add_feed(rand_char(), i == len - 1);
            end
            settle();
            r = $urandom_range(9);
            len = words_left();
            if (r == 0)
                len = $urandom_range(len);
            else if (r == 1)
                len = len + $urandom_range(3, 1);
            add_pulls(len);
            settle();
        end

        settle();
        if (fails == 0)
            $display("pdf417_text_rs_encoder regression: pass");
        else
            $display("pdf417_text_rs_encoder regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/p417_pkg.sv
hw/rtl/p417_mulmod.sv
hw/rtl/pdf417_text_rs_encoder.sv
hw/rtl/p417_checker.sv
tb/tb_pdf417_text_rs_encoder.sv
